@@ src/sparse_table_range_min_core_assert.svh @@
// assertion macros shared by the range-minimum engine modules
// expects a clock named aclk and an active-low reset named aresetn in scope
`ifndef SPARSE_TABLE_RANGE_MIN_CORE_ASSERT_SVH
`define SPARSE_TABLE_RANGE_MIN_CORE_ASSERT_SVH

// condition holds at every clock edge out of reset
`define STRM_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("strm assertion failed");

// antecedent implies consequent in the same cycle
`define STRM_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("strm assertion failed");

`endif

@@ src/strm_pkg.sv @@
// shared types and constants for the sparse-table range-minimum engine
// no dependencies
package strm_pkg;

    localparam int FUNC_W = 2;
    localparam int VALUE_W = 32;
    localparam int POS_W = 10;

    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int LEVELS_DEF = 11;

    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_APPEND,
        OP_QUERY
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   lo;
        logic [POS_W-1:0]   hi;
    } item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_L0,
        ST_B_LVL,
        ST_B_TAB,
        ST_B_ELEM,
        ST_B_WR,
        ST_Q_TAB,
        ST_Q_ELEM,
        ST_Q_RES
    } state_t;

endpackage

@@ src/strm_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module strm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/strm_front.sv @@
// front end: accepts input words, decodes func, queues commands for the back end
// depends on strm_pkg
module strm_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [strm_pkg::FUNC_W-1:0]   s_func,
    input  logic [strm_pkg::VALUE_W-1:0]  s_value,
    input  logic [strm_pkg::POS_W-1:0]    s_lo,
    input  logic [strm_pkg::POS_W-1:0]    s_hi,
    output logic                          q_valid,
    output strm_pkg::item_t               q_item,
    input  logic                          q_pop
);

    strm_pkg::item_t slot_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      fill_reg, fill_next;
    logic            push;
    logic            keep;
    strm_pkg::op_t   op;

    // decode func, unused code is accepted and dropped
    always_comb begin
        keep = 1'b1;
        op = strm_pkg::OP_CLEAR;
        unique case (s_func)
            strm_pkg::FUNC_CLEAR:  op = strm_pkg::OP_CLEAR;
            strm_pkg::FUNC_APPEND: op = strm_pkg::OP_APPEND;
            strm_pkg::FUNC_QUERY:  op = strm_pkg::OP_QUERY;
            default:               keep = 1'b0;
        endcase
    end

    assign s_ready = (fill_reg != 2'd2);
    assign push = s_valid && s_ready && keep;
    assign q_valid = (fill_reg != 2'd0);
    assign q_item = slot_reg[rd_ptr_reg];

    // queue pointers
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ (q_pop && q_valid);
        fill_next = fill_reg + 2'(push) - 2'(q_pop && q_valid);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg <= fill_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= '{op: op, value: s_value, lo: s_lo, hi: s_hi};
        end
    end

endmodule

@@ src/strm_back.sv @@
// back end: element store, sparse table build and range queries
// depends on strm_pkg, strm_ram and the assertion macro header
`include "sparse_table_range_min_core_assert.svh"
module strm_back #(
    parameter int MAX_ELEMENTS = strm_pkg::MAX_ELEMENTS_DEF,
    parameter int LEVELS = strm_pkg::LEVELS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_valid,
    input  strm_pkg::item_t              q_item,
    output logic                         q_pop,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [strm_pkg::VALUE_W-1:0] m_min_value,
    output logic [strm_pkg::POS_W-1:0]   m_min_index,
    output logic                         m_error
);

    localparam int IDX_W = $clog2(MAX_ELEMENTS);
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int LW = $clog2(LEVELS);
    localparam int JW = $clog2(LEVELS + 1);
    localparam int TAW = LW + IDX_W;
    localparam int TDEPTH = LEVELS << IDX_W;
    localparam int CMP_W = (CNT_W > strm_pkg::POS_W) ? CNT_W : strm_pkg::POS_W;
    localparam int VW = strm_pkg::VALUE_W;

    strm_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             tvalid_reg, tvalid_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [JW-1:0]    j_reg, j_next;
    logic [strm_pkg::POS_W-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic             err_reg, err_next;
    logic             m_valid_reg, m_valid_next;
    logic [VW-1:0]    val_reg, val_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             merr_reg, merr_next;

    // ram ports
    logic             e_we, e_re;
    logic [IDX_W-1:0] e_waddr, e_raddr_a, e_raddr_b;
    logic [VW-1:0]    e_wdata, e_rdata_a, e_rdata_b;
    logic             t_we, t_re;
    logic [TAW-1:0]   t_waddr, t_raddr_a, t_raddr_b;
    logic [IDX_W-1:0] t_wdata, t_rdata_a, t_rdata_b;

    // shared conditions
    logic             item_err;
    logic             lvl_ok;
    logic             entry_ok;
    logic [CNT_W-1:0] span;
    logic [CNT_W-1:0] half;
    logic [LW-1:0]    jm1;
    logic [IDX_W-1:0] q_lo, q_hi;
    logic [IDX_W:0]   q_len;
    logic [LW-1:0]    q_k;
    logic [IDX_W-1:0] q_rstart;
    logic             a_lt_b, b_lt_a;
    logic             out_free;

    // floor log2 of the query length, limited to the top level
    function automatic logic [LW-1:0] level_of(input logic [IDX_W:0] len);
        int kk;
        kk = 0;
        for (int b = 0; b <= IDX_W; b++) begin
            if (len[b]) begin
                kk = b;
            end
        end
        if (kk > LEVELS - 1) begin
            kk = LEVELS - 1;
        end
        return LW'(kk);
    endfunction

    assign item_err = (CMP_W'(q_item.lo) > CMP_W'(q_item.hi)) ||
                      (CMP_W'(q_item.hi) >= CMP_W'(cnt_reg));
    assign span = CNT_W'(1) << j_reg;
    assign half = CNT_W'(1) << (j_reg - JW'(1));
    assign jm1 = LW'(j_reg - JW'(1));
    assign lvl_ok = (j_reg < JW'(LEVELS)) && ((cnt_reg >> j_reg) != '0);
    assign entry_ok = ({1'b0, i_reg} + {1'b0, span}) <= {1'b0, cnt_reg};
    assign q_lo = IDX_W'(lo_reg);
    assign q_hi = IDX_W'(hi_reg);
    assign q_len = {1'b0, q_hi} - {1'b0, q_lo} + (IDX_W+1)'(1);
    assign q_k = level_of(q_len);
    assign q_rstart = IDX_W'({1'b0, q_hi} + (IDX_W+1)'(1) - ((IDX_W+1)'(1) << q_k));
    assign a_lt_b = $signed(e_rdata_a) < $signed(e_rdata_b);
    assign b_lt_a = $signed(e_rdata_b) < $signed(e_rdata_a);
    assign out_free = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            strm_pkg::ST_IDLE: begin
                if (q_valid && q_item.op == strm_pkg::OP_QUERY) begin
                    if (!tvalid_reg) begin
                        state_next = strm_pkg::ST_L0;
                    end else if (item_err) begin
                        state_next = strm_pkg::ST_Q_RES;
                    end else begin
                        state_next = strm_pkg::ST_Q_TAB;
                    end
                end
            end
            strm_pkg::ST_L0: begin
                if (i_reg == cnt_reg) begin
                    state_next = strm_pkg::ST_B_LVL;
                end
            end
            strm_pkg::ST_B_LVL: begin
                if (lvl_ok) begin
                    state_next = strm_pkg::ST_B_TAB;
                end else if (err_reg) begin
                    state_next = strm_pkg::ST_Q_RES;
                end else begin
                    state_next = strm_pkg::ST_Q_TAB;
                end
            end
            strm_pkg::ST_B_TAB: begin
                state_next = entry_ok ? strm_pkg::ST_B_ELEM : strm_pkg::ST_B_LVL;
            end
            strm_pkg::ST_B_ELEM: state_next = strm_pkg::ST_B_WR;
            strm_pkg::ST_B_WR:   state_next = strm_pkg::ST_B_TAB;
            strm_pkg::ST_Q_TAB:  state_next = strm_pkg::ST_Q_ELEM;
            strm_pkg::ST_Q_ELEM: state_next = strm_pkg::ST_Q_RES;
            strm_pkg::ST_Q_RES: begin
                if (out_free) begin
                    state_next = strm_pkg::ST_IDLE;
                end
            end
            default: state_next = strm_pkg::ST_IDLE;
        endcase
    end

    // datapath and ram control
    always_comb begin
        q_pop = 1'b0;
        cnt_next = cnt_reg;
        tvalid_next = tvalid_reg;
        i_next = i_reg;
        j_next = j_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        err_next = err_reg;
        val_next = val_reg;
        idx_next = idx_reg;
        merr_next = merr_reg;
        m_valid_next = m_valid_reg && !m_ready;
        e_we = 1'b0;
        e_waddr = IDX_W'(cnt_reg);
        e_wdata = q_item.value;
        e_re = 1'b0;
        e_raddr_a = t_rdata_a;
        e_raddr_b = t_rdata_b;
        t_we = 1'b0;
        t_waddr = {LW'(j_reg), IDX_W'(i_reg)};
        t_wdata = IDX_W'(i_reg);
        t_re = 1'b0;
        t_raddr_a = {jm1, IDX_W'(i_reg)};
        t_raddr_b = {jm1, IDX_W'(i_reg + half)};
        unique case (state_reg)
            strm_pkg::ST_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    unique case (q_item.op)
                        strm_pkg::OP_CLEAR: begin
                            cnt_next = '0;
                            tvalid_next = 1'b0;
                        end
                        strm_pkg::OP_APPEND: begin
                            if (cnt_reg < CNT_W'(MAX_ELEMENTS)) begin
                                e_we = 1'b1;
                                cnt_next = cnt_reg + CNT_W'(1);
                                tvalid_next = 1'b0;
                            end
                        end
                        default: begin
                            lo_next = q_item.lo;
                            hi_next = q_item.hi;
                            err_next = item_err;
                            i_next = '0;
                            j_next = JW'(1);
                        end
                    endcase
                end
            end
            strm_pkg::ST_L0: begin
                // level zero holds each entry's own index
                if (i_reg != cnt_reg) begin
                    t_we = 1'b1;
                    t_waddr = {LW'(0), IDX_W'(i_reg)};
                    i_next = i_reg + CNT_W'(1);
                end
            end
            strm_pkg::ST_B_LVL: begin
                i_next = '0;
                if (!lvl_ok) begin
                    tvalid_next = 1'b1;
                end
            end
            strm_pkg::ST_B_TAB: begin
                if (entry_ok) begin
                    t_re = 1'b1;
                end else begin
                    j_next = j_reg + JW'(1);
                end
            end
            strm_pkg::ST_B_ELEM: e_re = 1'b1;
            strm_pkg::ST_B_WR: begin
                // right-hand index wins on equal values
                t_we = 1'b1;
                t_wdata = a_lt_b ? t_rdata_a : t_rdata_b;
                i_next = i_reg + CNT_W'(1);
            end
            strm_pkg::ST_Q_TAB: begin
                t_re = 1'b1;
                t_raddr_a = {q_k, q_lo};
                t_raddr_b = {q_k, q_rstart};
            end
            strm_pkg::ST_Q_ELEM: e_re = 1'b1;
            strm_pkg::ST_Q_RES: begin
                // left block wins on equal values
                if (out_free) begin
                    m_valid_next = 1'b1;
                    merr_next = err_reg;
                    if (err_reg) begin
                        val_next = '0;
                        idx_next = '0;
                    end else if (b_lt_a) begin
                        val_next = e_rdata_b;
                        idx_next = t_rdata_b;
                    end else begin
                        val_next = e_rdata_a;
                        idx_next = t_rdata_a;
                    end
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= strm_pkg::ST_IDLE;
            cnt_reg <= '0;
            tvalid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            tvalid_reg <= tvalid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        i_reg <= i_next;
        j_reg <= j_next;
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        err_reg <= err_next;
        val_reg <= val_next;
        idx_reg <= idx_next;
        merr_reg <= merr_next;
    end

    assign m_valid = m_valid_reg;
    assign m_min_value = val_reg;
    assign m_min_index = strm_pkg::POS_W'(idx_reg);
    assign m_error = merr_reg;

    // two copies of each store give two reads a cycle
    strm_ram #(.WIDTH(VW), .DEPTH(MAX_ELEMENTS)) u_elem_a (
        .aclk(aclk), .wr_en(e_we), .wr_addr(e_waddr), .wr_data(e_wdata),
        .rd_en(e_re), .rd_addr(e_raddr_a), .rd_data(e_rdata_a)
    );
    strm_ram #(.WIDTH(VW), .DEPTH(MAX_ELEMENTS)) u_elem_b (
        .aclk(aclk), .wr_en(e_we), .wr_addr(e_waddr), .wr_data(e_wdata),
        .rd_en(e_re), .rd_addr(e_raddr_b), .rd_data(e_rdata_b)
    );
    strm_ram #(.WIDTH(IDX_W), .DEPTH(TDEPTH)) u_tab_a (
        .aclk(aclk), .wr_en(t_we), .wr_addr(t_waddr), .wr_data(t_wdata),
        .rd_en(t_re), .rd_addr(t_raddr_a), .rd_data(t_rdata_a)
    );
    strm_ram #(.WIDTH(IDX_W), .DEPTH(TDEPTH)) u_tab_b (
        .aclk(aclk), .wr_en(t_we), .wr_addr(t_waddr), .wr_data(t_wdata),
        .rd_en(t_re), .rd_addr(t_raddr_b), .rd_data(t_rdata_b)
    );

    // checks
    `STRM_ASSERT_ALWAYS(a_cnt_bound, cnt_reg <= CNT_W'(MAX_ELEMENTS))
    `STRM_ASSERT_IMPLY(a_build_stale, t_we, !tvalid_reg)
    `STRM_ASSERT_IMPLY(a_err_zero, m_valid_reg && merr_reg, val_reg == '0 && idx_reg == '0)

endmodule

@@ src/sparse_table_range_min_core.sv @@
// Range-minimum engine over up to MAX_ELEMENTS signed 32-bit words. func 0 clears, func 1
// appends, func 2 queries lo..hi and returns the minimum, its index and an error flag; func 3
// is taken and dropped. A query with a fresh table reads both table copies, then both
// element copies, then registers its result when the output is free; an out-of-range query
// skips the reads. The first query after the array changes first rebuilds the argmin table:
// level zero entry by entry, then per higher level a level check and, per entry, a table
// read, an element read and a write of the winner; a last level check ends the build. Each
// memory copy has one read port. A two-word queue takes words during a rebuild until full.
// depends on strm_pkg, strm_front and strm_back
module sparse_table_range_min_core #(
    parameter int MAX_ELEMENTS = strm_pkg::MAX_ELEMENTS_DEF,
    parameter int LEVELS = strm_pkg::LEVELS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [strm_pkg::FUNC_W-1:0]  s_func,
    input  logic [strm_pkg::VALUE_W-1:0] s_value,
    input  logic [strm_pkg::POS_W-1:0]   s_lo,
    input  logic [strm_pkg::POS_W-1:0]   s_hi,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [strm_pkg::VALUE_W-1:0] m_min_value,
    output logic [strm_pkg::POS_W-1:0]   m_min_index,
    output logic                         m_error
);

    logic            q_valid;
    logic            q_pop;
    strm_pkg::item_t q_item;

    // decode and queue
    strm_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_func(s_func), .s_value(s_value), .s_lo(s_lo), .s_hi(s_hi),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
    );

    // storage, table build and query
    strm_back #(.MAX_ELEMENTS(MAX_ELEMENTS), .LEVELS(LEVELS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_min_value(m_min_value), .m_min_index(m_min_index), .m_error(m_error)
    );

endmodule

@@ test/strm_checker.sv @@
// result checker for the sparse-table range-minimum engine: predicts and compares words
// depends on strm_pkg for the function codes and field widths
`timescale 1ns / 1ps

module strm_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic [strm_pkg::FUNC_W-1:0]  s_func,
    input  logic [strm_pkg::VALUE_W-1:0] s_value,
    input  logic [strm_pkg::POS_W-1:0]   s_lo,
    input  logic [strm_pkg::POS_W-1:0]   s_hi,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic [strm_pkg::VALUE_W-1:0] m_min_value,
    input  logic [strm_pkg::POS_W-1:0]   m_min_index,
    input  logic                         m_error,
    output int                           mismatches,
    output int                           pending
);

    localparam int DEPTH = strm_pkg::MAX_ELEMENTS_DEF;
    localparam int LVLS = strm_pkg::LEVELS_DEF;

    typedef struct {
        logic signed [strm_pkg::VALUE_W-1:0] min_value;
        logic [strm_pkg::POS_W-1:0]          min_index;
        logic                                error;
    } min_result_t;

    logic signed [strm_pkg::VALUE_W-1:0] elems [DEPTH];
    logic [strm_pkg::POS_W-1:0]          argmin [LVLS][DEPTH];
    int                                  elem_count;
    bit                                  argmin_fresh;
    min_result_t                         min_results_due [$];

    initial begin
        mismatches = 0;
        pending = 0;
        elem_count = 0;
        argmin_fresh = 0;
    end

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // rebuild argmin levels; equal halves keep the right-hand index
    task automatic rebuild_argmin();
        int j;
        int i;
        int half;
        logic [strm_pkg::POS_W-1:0] p;
        logic [strm_pkg::POS_W-1:0] q;
        for (i = 0; i < elem_count; i++) argmin[0][i] = strm_pkg::POS_W'(i);
        for (j = 1; j < LVLS && (1 << j) <= elem_count; j++) begin
            half = 1 << (j - 1);
            for (i = 0; i + (1 << j) <= elem_count; i++) begin
                p = argmin[j-1][i];
                q = argmin[j-1][i+half];
                argmin[j][i] = (elems[p] < elems[q]) ? p : q;
            end
        end
        argmin_fresh = 1;
    endtask

    // range minimum from two overlapping blocks, left block wins ties
    task automatic predict_query(input int lo, input int hi);
        min_result_t r;
        int len;
        int k;
        logic [strm_pkg::POS_W-1:0] p;
        logic [strm_pkg::POS_W-1:0] q;
        if (!argmin_fresh) rebuild_argmin();
        if (lo > hi || hi >= elem_count) begin
            r.min_value = '0;
            r.min_index = '0;
            r.error = 1'b1;
        end else begin
            len = hi - lo + 1;
            k = 0;
            while (k + 1 < LVLS && (2 << k) <= len) k++;
            p = argmin[k][lo];
            q = argmin[k][hi + 1 - (1 << k)];
            r.min_index = (elems[q] < elems[p]) ? q : p;
            r.min_value = elems[r.min_index];
            r.error = 1'b0;
        end
        min_results_due = {min_results_due, r};
    endtask

    always @(posedge aclk) begin
        min_result_t want;
        if (aresetn) begin
            // input word accepted
            if (s_valid && s_ready) begin
                case (s_func)
                    strm_pkg::FUNC_CLEAR: begin
                        elem_count = 0;
                        argmin_fresh = 0;
                    end
                    strm_pkg::FUNC_APPEND: begin
                        if (elem_count < DEPTH) begin
                            elems[elem_count] = s_value;
                            elem_count++;
                            argmin_fresh = 0;
                        end
                    end
                    strm_pkg::FUNC_QUERY: predict_query(int'(s_lo), int'(s_hi));
                    default: ;
                endcase
            end
            // result word accepted
            if (m_valid && m_ready) begin
                if (min_results_due.size() == 0) begin
                    report("result word with none expected");
                end else begin
                    want = min_results_due.pop_front();
                    if (m_error !== want.error)
                        report($sformatf("error got %b want %b", m_error, want.error));
                    if (m_min_value !== want.min_value)
                        report($sformatf("min_value got %0d want %0d",
                            $signed(m_min_value), want.min_value));
                    if (m_min_index !== want.min_index)
                        report($sformatf("min_index got %0d want %0d",
                            m_min_index, want.min_index));
                end
            end
            pending = min_results_due.size();
        end
    end

endmodule

@@ test/sparse_table_range_min_core_tb.sv @@
// stimulus and verdict for the sparse-table range-minimum engine
// depends on strm_pkg, sparse_table_range_min_core and strm_checker
`timescale 1ns / 1ps

module sparse_table_range_min_core_tb;

    localparam int CYCLE_LIMIT = 3000000;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [strm_pkg::FUNC_W-1:0]   s_func = strm_pkg::FUNC_CLEAR;
    logic [strm_pkg::VALUE_W-1:0]  s_value = '0;
    logic [strm_pkg::POS_W-1:0]    s_lo = '0;
    logic [strm_pkg::POS_W-1:0]    s_hi = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [strm_pkg::VALUE_W-1:0]  m_min_value;
    logic [strm_pkg::POS_W-1:0]    m_min_index;
    logic                          m_error;
    int                            mismatches;
    int                            pending;

    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;
    int                  hold_request = 0;
    int                  hold_left = 0;
    int                  cycles = 0;
    int                  loaded = 0;
    int                  words_sent = 0;

    sparse_table_range_min_core u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_value     (s_value),
        .s_lo        (s_lo),
        .s_hi        (s_hi),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_min_value (m_min_value),
        .m_min_index (m_min_index),
        .m_error     (m_error)
    );

    strm_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_value     (s_value),
        .s_lo        (s_lo),
        .s_hi        (s_hi),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_min_value (m_min_value),
        .m_min_index (m_min_index),
        .m_error     (m_error),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    always #1 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side: random stalls plus long hold-offs on request
    always @(posedge aclk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(1, 100) > recv_stall_pct);
        end
    end

    // offer one word, with random idle cycles ahead of it
    task automatic send(input logic [strm_pkg::FUNC_W-1:0] f,
                        input logic [strm_pkg::VALUE_W-1:0] v,
                        input int lo, input int hi);
        while ($urandom_range(1, 100) <= send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= f;
        s_value <= v;
        s_lo <= strm_pkg::POS_W'(lo);
        s_hi <= strm_pkg::POS_W'(hi);
        do @(posedge aclk); while (!s_ready);
        if (f == strm_pkg::FUNC_CLEAR) loaded = 0;
        if (f == strm_pkg::FUNC_APPEND && loaded < strm_pkg::MAX_ELEMENTS_DEF) loaded++;
        if (f != strm_pkg::FUNC_UNUSED) words_sent++;
    endtask

    function automatic logic [strm_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0: return strm_pkg::VALUE_W'($urandom_range(0, 6) - 3);
            1: return $urandom();
            2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: return strm_pkg::VALUE_W'($urandom_range(0, 2000) - 1000);
        endcase
    endfunction

    // mostly in-range queries, some out of range or reversed
    task automatic send_query();
        int lo;
        int hi;
        if (loaded > 0 && $urandom_range(1, 100) <= 80) begin
            lo = $urandom_range(0, loaded - 1);
            hi = $urandom_range(lo, loaded - 1);
        end else begin
            lo = $urandom_range(0, 1023);
            hi = $urandom_range(0, 1023);
        end
        send(strm_pkg::FUNC_QUERY, '0, lo, hi);
    endtask

    task automatic set_phase(input int ph);
        case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
            default: begin send_idle_pct = 7; recv_stall_pct = 7; end
        endcase
    endtask

    initial begin
        int n;
        int i;
        int ph;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, ties, errors, unused code, stale table
        send(strm_pkg::FUNC_CLEAR, '0, 0, 0);
        send(strm_pkg::FUNC_QUERY, '0, 0, 0);
        send(strm_pkg::FUNC_APPEND, 32'h8000_0000, 0, 0);
        send(strm_pkg::FUNC_APPEND, 32'h7fff_ffff, 0, 0);
        send(strm_pkg::FUNC_APPEND, 32'h0000_0000, 0, 0);
        send(strm_pkg::FUNC_APPEND, 32'hffff_ffff, 0, 0);
        send(strm_pkg::FUNC_APPEND, 32'd5, 0, 0);
        send(strm_pkg::FUNC_APPEND, 32'd5, 0, 0);
        send(strm_pkg::FUNC_APPEND, 32'hffff_ffff, 0, 0);
        send(strm_pkg::FUNC_UNUSED, 32'hffff_ffff, 1023, 1023);
        send(strm_pkg::FUNC_QUERY, '0, 0, 6);
        send(strm_pkg::FUNC_QUERY, '0, 3, 3);
        send(strm_pkg::FUNC_QUERY, '0, 4, 5);
        send(strm_pkg::FUNC_QUERY, '0, 3, 6);
        send(strm_pkg::FUNC_QUERY, '0, 1, 6);
        send(strm_pkg::FUNC_QUERY, '0, 6, 0);
        send(strm_pkg::FUNC_QUERY, '0, 0, 7);
        send(strm_pkg::FUNC_QUERY, '0, 1023, 1023);
        send(strm_pkg::FUNC_APPEND, 32'h8000_0000, 0, 0);
        send(strm_pkg::FUNC_QUERY, '0, 0, 7);
        send(strm_pkg::FUNC_QUERY, '0, 2, 4);
        send(strm_pkg::FUNC_CLEAR, '0, 0, 0);
        send(strm_pkg::FUNC_QUERY, '0, 0, 0);

        // long receiver hold-off while queries keep coming, then drain
        send(strm_pkg::FUNC_APPEND, 32'd9, 0, 0);
        send(strm_pkg::FUNC_APPEND, 32'd9, 0, 0);
        send(strm_pkg::FUNC_QUERY, '0, 0, 1);
        hold_request = 400;
        for (i = 0; i < 20; i++) send_query();
        s_valid <= 1'b0;
        wait (pending == 0);

        // random loads and queries through the idling phases
        ph = 0;
        while (words_sent < 500) begin
            set_phase(ph);
            ph++;
            if ($urandom_range(0, 3) != 0) send(strm_pkg::FUNC_CLEAR, '0, 0, 0);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
            for (i = 0; i < n; i++) send(strm_pkg::FUNC_APPEND, pick_value(), 0, 0);
            n = $urandom_range(3, 15);
            for (i = 0; i < n; i++) begin
                if ($urandom_range(0, 19) == 0) send(strm_pkg::FUNC_UNUSED, $urandom(), 0, 0);
                send_query();
            end
        end
        s_valid <= 1'b0;

        wait (pending == 0);
        repeat (200) @(posedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
